### hw/rtl/wlib_pkg.sv
`default_nettype none

package wlib_pkg;

	// Sizes
	localparam int NUM_BACKENDS = 4;
	localparam int NUM_CLIENTS  = 16;
	localparam int COUNT_WIDTH  = 16;
	localparam int WEIGHT_W     = 8;
	localparam int BIDX_W       = 2;
	localparam int CIDX_W       = 4;
	localparam int LIVE_W       = 3;
	localparam int CURSOR_W     = 64;
	localparam int TOTAL_W      = 10;
	localparam int DIV_BITS     = 4;
	localparam int DIV_STEPS    = CURSOR_W / DIV_BITS;
	localparam int DSTEP_W      = 4;
	localparam int CFG_IDX_W    = 3;

	// Request op codes
	localparam logic [1:0] OP_ROUTE    = 2'd0;
	localparam logic [1:0] OP_STICKY   = 2'd1;
	localparam logic [1:0] OP_COMPLETE = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NONE    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BACKENDS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEALTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT0  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT1  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT2  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT3  = 3'd5;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [WEIGHT_W-1:0]    weight_t;

	// Clamp a backends_in_use value to the number of backends
	function automatic logic [LIVE_W-1:0] clamp_live(input logic [LIVE_W-1:0] v);
		return (v > LIVE_W'(NUM_BACKENDS)) ? LIVE_W'(NUM_BACKENDS) : v;
	endfunction

	// Backend is in use and marked healthy
	function automatic logic is_healthy(input logic [BIDX_W-1:0] i,
		input logic [LIVE_W-1:0] live, input logic [NUM_BACKENDS-1:0] mask);
		return (LIVE_W'(i) < live) && mask[i];
	endfunction

endpackage

`default_nettype wire

### hw/rtl/weighted_least_inflight_balancer.sv
`default_nettype none

// Channel    | Signals                                   | Transfer when
// -----------+-------------------------------------------+-----------------------
// request    | start, busy, op, client_index, backend_index | start & !busy
// result     | done, status, chosen_backend              | done (one cycle)
// config     | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid & cfg_ready
//
// Completions, invalid ops and sticky hits finish from S_DISPATCH. A routed request
// goes on through S_SCAN (min scan), S_SUM (ticket sum), S_DIV (cursor mod total,
// 4 bits a cycle) and S_PICK (ticket pick); the divider is the longest step.
// busy is high from the accepting edge until the edge that raises done.
// arst_n resets all state, with health mask and weights set to ones; the result side cannot stall.
module weighted_least_inflight_balancer (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire  [1:0]                       op,
	input  wire  [wlib_pkg::CIDX_W-1:0]      client_index,
	input  wire  [wlib_pkg::BIDX_W-1:0]      backend_index,
	output logic                             done,
	output logic [1:0]                       status,
	output logic [wlib_pkg::BIDX_W-1:0]      chosen_backend,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [wlib_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [wlib_pkg::WEIGHT_W-1:0]    cfg_data
);
	import wlib_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_DISPATCH, S_SCAN, S_SUM, S_DIV, S_PICK
	} state_t;

	state_t                    state_q;
	logic                      busy_q, done_q;
	logic [1:0]                status_q;
	logic [BIDX_W-1:0]         chosen_q;

	// Configuration
	logic [LIVE_W-1:0]         backends_q;
	logic [NUM_BACKENDS-1:0]   mask_q;
	weight_t                   weight_q [NUM_BACKENDS];

	// Balancing state
	count_t                    cnt_q [NUM_BACKENDS];
	logic [CURSOR_W-1:0]       cursor_q;
	logic                      least_mode_q;
	logic [NUM_CLIENTS-1:0]    aff_valid_q;
	logic [BIDX_W-1:0]         aff_be_q [NUM_CLIENTS];

	// Request and sequencer registers
	logic [1:0]                op_q;
	logic [CIDX_W-1:0]         client_q;
	logic [BIDX_W-1:0]         bidx_q;
	logic [BIDX_W-1:0]         idx_q;
	logic                      any_q;
	count_t                    least_q;
	logic [TOTAL_W-1:0]        total_q;
	logic [CURSOR_W-1:0]       div_q;
	logic [TOTAL_W-1:0]        rem_q;
	logic [DSTEP_W-1:0]        dstep_q;

	// Combinational helpers
	logic [LIVE_W-1:0]         live;
	logic [LIVE_W-1:0]         cfg_live;
	logic [BIDX_W-1:0]         aff_be;
	logic [BIDX_W-1:0]         rd_sel;
	count_t                    cnt_rd;
	count_t                    cnt_inc;
	weight_t                   w_rd;
	logic                      hlt_sel;
	logic                      in_pool;
	logic                      scan_take;
	logic                      aff_hit;
	logic                      last_idx;
	logic [TOTAL_W-1:0]        total_nx;
	logic [TOTAL_W-1:0]        rem_nx;
	logic [TOTAL_W:0]          trial;
	logic                      cfg_xfer;

	assign busy      = busy_q;
	assign done      = done_q;
	assign status    = status_q;
	assign chosen_backend = chosen_q;
	assign cfg_ready = ~busy_q;
	assign cfg_xfer  = cfg_valid & ~busy_q;

	// Shared read port on counts, weight read at idx_q, plus pool tests
	always_comb begin
		live     = clamp_live(backends_q);
		cfg_live = clamp_live(cfg_data[LIVE_W-1:0]);
		aff_be   = aff_be_q[client_q];
		aff_hit  = (op_q == OP_STICKY) && aff_valid_q[client_q] &&
			is_healthy(aff_be, live, mask_q);
		case (state_q)
			S_DISPATCH: rd_sel = (op_q == OP_STICKY) ? aff_be : bidx_q;
			default:    rd_sel = idx_q;
		endcase
		cnt_rd    = cnt_q[rd_sel];
		cnt_inc   = (cnt_rd == {COUNT_WIDTH{1'b1}}) ? cnt_rd : cnt_rd + 1'b1;
		w_rd      = weight_q[idx_q];
		hlt_sel   = is_healthy(rd_sel, live, mask_q);
		in_pool   = hlt_sel && (!least_mode_q || (cnt_rd == least_q));
		scan_take = hlt_sel && (!any_q || (cnt_rd < least_q));
		last_idx  = (idx_q == BIDX_W'(NUM_BACKENDS - 1));
		total_nx  = total_q + (in_pool ? TOTAL_W'(w_rd) : '0);
	end

	// Divider step: four dividend bits per cycle
	always_comb begin
		rem_nx = rem_q;
		trial  = '0;
		for (int k = 0; k < DIV_BITS; k++) begin
			trial = {rem_nx, div_q[CURSOR_W-1-k]};
			if (trial >= {1'b0, total_q})
				trial = trial - {1'b0, total_q};
			rem_nx = trial[TOTAL_W-1:0];
		end
	end

	// Sequencer, state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			busy_q       <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= ST_OK;
			chosen_q     <= '0;
			backends_q   <= '0;
			mask_q       <= '1;
			for (int i = 0; i < NUM_BACKENDS; i++) begin
				weight_q[i] <= WEIGHT_W'(1);
				cnt_q[i]    <= '0;
			end
			for (int i = 0; i < NUM_CLIENTS; i++)
				aff_be_q[i] <= '0;
			cursor_q     <= '0;
			least_mode_q <= 1'b0;
			aff_valid_q  <= '0;
			op_q         <= '0;
			client_q     <= '0;
			bidx_q       <= '0;
			idx_q        <= '0;
			any_q        <= 1'b0;
			least_q      <= '0;
			total_q      <= '0;
			div_q        <= '0;
			rem_q        <= '0;
			dstep_q      <= '0;
		end else begin
			done_q <= 1'b0;

			// Register writes, taken while idle
			if (cfg_xfer) begin
				case (cfg_index)
					REG_BACKENDS: begin
						backends_q <= cfg_data[LIVE_W-1:0];
						for (int i = 0; i < NUM_BACKENDS; i++)
							if (LIVE_W'(i) >= cfg_live)
								cnt_q[i] <= '0;
					end
					REG_HEALTH, REG_WEIGHT0, REG_WEIGHT1, REG_WEIGHT2, REG_WEIGHT3: begin
						case (cfg_index)
							REG_HEALTH:  mask_q      <= cfg_data[NUM_BACKENDS-1:0];
							REG_WEIGHT0: weight_q[0] <= cfg_data;
							REG_WEIGHT1: weight_q[1] <= cfg_data;
							REG_WEIGHT2: weight_q[2] <= cfg_data;
							REG_WEIGHT3: weight_q[3] <= cfg_data;
							default:     ;
						endcase
						cursor_q     <= '0;
						least_mode_q <= 1'b0;
						for (int i = 0; i < NUM_BACKENDS; i++)
							cnt_q[i] <= '0;
					end
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= op;
						client_q <= client_index;
						bidx_q   <= backend_index;
						busy_q   <= 1'b1;
						state_q  <= S_DISPATCH;
					end
				end

				// Completion, invalid op, sticky hit or start of a routing pass
				S_DISPATCH: begin
					chosen_q <= '0;
					status_q <= ST_OK;
					if (op_q == OP_COMPLETE) begin
						if ((LIVE_W'(bidx_q) >= live) || (cnt_rd == '0)) begin
							status_q <= ST_INVALID;
						end else begin
							cnt_q[bidx_q] <= cnt_rd - 1'b1;
							least_mode_q  <= 1'b1;
						end
						done_q  <= 1'b1;
						busy_q  <= 1'b0;
						state_q <= S_IDLE;
					end else if (op_q != OP_ROUTE && op_q != OP_STICKY) begin
						status_q <= ST_INVALID;
						done_q   <= 1'b1;
						busy_q   <= 1'b0;
						state_q  <= S_IDLE;
					end else if (aff_hit) begin
						chosen_q      <= aff_be;
						cnt_q[aff_be] <= cnt_inc;
						done_q        <= 1'b1;
						busy_q        <= 1'b0;
						state_q       <= S_IDLE;
					end else begin
						idx_q   <= '0;
						any_q   <= 1'b0;
						state_q <= S_SCAN;
					end
				end

				// Minimum in-flight count over the healthy backends
				S_SCAN: begin
					if (scan_take)
						least_q <= cnt_rd;
					any_q <= any_q | hlt_sel;
					idx_q <= idx_q + 1'b1;
					if (last_idx) begin
						if (!(any_q | hlt_sel)) begin
							status_q <= ST_NONE;
							done_q   <= 1'b1;
							busy_q   <= 1'b0;
							state_q  <= S_IDLE;
						end else begin
							total_q <= '0;
							state_q <= S_SUM;
						end
					end
				end

				// Ticket total of the pool
				S_SUM: begin
					total_q <= total_nx;
					idx_q   <= idx_q + 1'b1;
					if (last_idx) begin
						if (total_nx == '0) begin
							status_q <= ST_NONE;
							done_q   <= 1'b1;
							busy_q   <= 1'b0;
							state_q  <= S_IDLE;
						end else begin
							div_q    <= cursor_q;
							cursor_q <= cursor_q + 1'b1;
							rem_q    <= '0;
							dstep_q  <= '0;
							state_q  <= S_DIV;
						end
					end
				end

				// Cursor mod total
				S_DIV: begin
					rem_q   <= rem_nx;
					div_q   <= div_q << DIV_BITS;
					dstep_q <= dstep_q + 1'b1;
					if (dstep_q == DSTEP_W'(DIV_STEPS - 1)) begin
						idx_q   <= '0;
						state_q <= S_PICK;
					end
				end

				// Walk tickets to the chosen backend
				S_PICK: begin
					idx_q <= idx_q + 1'b1;
					if (in_pool && (rem_q < TOTAL_W'(w_rd))) begin
						chosen_q     <= idx_q;
						cnt_q[idx_q] <= cnt_inc;
						if (op_q == OP_STICKY) begin
							aff_valid_q[client_q] <= 1'b1;
							aff_be_q[client_q]    <= idx_q;
						end
						done_q  <= 1'b1;
						busy_q  <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						if (in_pool)
							rem_q <= rem_q - TOTAL_W'(w_rd);
						if (last_idx) begin
							status_q <= ST_NONE;
							done_q   <= 1'b1;
							busy_q   <= 1'b0;
							state_q  <= S_IDLE;
						end
					end
				end

				default: begin
					busy_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### tb/tb_top.sv
module tb_top;
	import wlib_pkg::*;

	// Codes the package leaves unnamed
	localparam logic [1:0]           OP_UNUSED    = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 40;
	localparam int LOAD_HITS     = 3;

	typedef struct packed {
		logic [1:0]        status;
		logic [BIDX_W-1:0] backend;
	} pick_t;

	// Clock, reset and block inputs, all known from time zero
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [1:0]           req_op = OP_ROUTE;
	logic [CIDX_W-1:0]    req_client = '0;
	logic [BIDX_W-1:0]    req_backend = '0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_BACKENDS;
	logic [WEIGHT_W-1:0]  cfg_data = '0;
	logic                 busy;
	logic                 done;
	logic [1:0]           status;
	logic [BIDX_W-1:0]    chosen_backend;
	logic                 cfg_ready;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	weighted_least_inflight_balancer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (req_op),
		.client_index  (req_client),
		.backend_index (req_backend),
		.done          (done),
		.status        (status),
		.chosen_backend(chosen_backend),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Balancer state as the testbench tracks it
	logic [LIVE_W-1:0]       m_live;
	logic [NUM_BACKENDS-1:0] m_health;
	weight_t                 m_weight [NUM_BACKENDS];
	count_t                  m_inflight [NUM_BACKENDS];
	logic [CURSOR_W-1:0]     m_cursor;
	logic                    m_least;
	logic                    m_aff_valid [NUM_CLIENTS];
	logic [BIDX_W-1:0]       m_aff_backend [NUM_CLIENTS];

	pick_t pending_picks [$];
	int    error_count = 0;
	int    burst_left = 0;
	bit    pacing_on = 1'b1;

	function automatic int live_backends();
		return (int'(m_live) > NUM_BACKENDS) ? NUM_BACKENDS : int'(m_live);
	endfunction

	function automatic logic backend_up(int i);
		return (i < live_backends()) && m_health[i];
	endfunction

	function automatic void restart_rotation();
		m_cursor = '0;
		m_least  = 1'b0;
		foreach (m_inflight[i]) m_inflight[i] = '0;
	endfunction

	function automatic void reset_model();
		m_live   = '0;
		m_health = '1;
		foreach (m_weight[i]) m_weight[i] = weight_t'(1);
		restart_rotation();
		foreach (m_aff_valid[i]) begin
			m_aff_valid[i]   = 1'b0;
			m_aff_backend[i] = '0;
		end
	endfunction

	// Count saturates at all ones
	function automatic void bump_inflight(int i);
		if (m_inflight[i] != '1)
			m_inflight[i] = m_inflight[i] + 1'b1;
	endfunction

	// Weighted round robin over the pool; -1 when no ticket exists
	function automatic int pick_weighted();
		logic            pool [NUM_BACKENDS];
		count_t          fewest;
		logic            any;
		longint unsigned total;
		longint unsigned slot;
		fewest = '0;
		any    = 1'b0;
		total  = 0;
		for (int i = 0; i < NUM_BACKENDS; i++) begin
			pool[i] = backend_up(i);
			if (pool[i] && (!any || m_inflight[i] < fewest))
				fewest = m_inflight[i];
			if (pool[i])
				any = 1'b1;
		end
		if (!any)
			return -1;
		// least-in-flight mode keeps only the minimum-count backends
		for (int i = 0; i < NUM_BACKENDS; i++) begin
			if (m_least && pool[i] && m_inflight[i] != fewest)
				pool[i] = 1'b0;
			if (pool[i])
				total += m_weight[i];
		end
		if (total == 0)
			return -1;
		slot     = m_cursor % total;
		m_cursor = m_cursor + 1'b1;
		for (int i = 0; i < NUM_BACKENDS; i++) begin
			if (pool[i]) begin
				if (slot < m_weight[i]) begin
					bump_inflight(i);
					return i;
				end
				slot -= m_weight[i];
			end
		end
		return -1;
	endfunction

	// Expected result of one request, updating the tracked state
	function automatic pick_t predict_pick(logic [1:0] op, logic [CIDX_W-1:0] client,
		logic [BIDX_W-1:0] bidx);
		pick_t res;
		int    c;
		res.status  = ST_OK;
		res.backend = '0;
		case (op)
			OP_ROUTE, OP_STICKY: begin
				if (op == OP_STICKY && m_aff_valid[client] &&
					backend_up(m_aff_backend[client])) begin
					res.backend = m_aff_backend[client];
					bump_inflight(res.backend);
				end else begin
					c = pick_weighted();
					if (c < 0) begin
						res.status = ST_NONE;
					end else begin
						res.backend = c[BIDX_W-1:0];
						if (op == OP_STICKY) begin
							m_aff_valid[client]   = 1'b1;
							m_aff_backend[client] = res.backend;
						end
					end
				end
			end
			OP_COMPLETE: begin
				if (int'(bidx) >= live_backends() || m_inflight[bidx] == '0) begin
					res.status = ST_INVALID;
				end else begin
					m_inflight[bidx] = m_inflight[bidx] - 1'b1;
					m_least = 1'b1;
				end
			end
			default: res.status = ST_INVALID;
		endcase
		return res;
	endfunction

	function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] data);
		case (idx)
			REG_BACKENDS: begin
				m_live = data[LIVE_W-1:0];
				// backends no longer in use drop their counts
				for (int i = live_backends(); i < NUM_BACKENDS; i++)
					m_inflight[i] = '0;
			end
			REG_HEALTH: begin
				m_health = data[NUM_BACKENDS-1:0];
				restart_rotation();
			end
			REG_WEIGHT0, REG_WEIGHT1, REG_WEIGHT2, REG_WEIGHT3: begin
				m_weight[int'(idx - REG_WEIGHT0)] = data;
				restart_rotation();
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		error_count++;
		$display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
	endtask

	// Result checker: one result per done cycle, in order
	always @(posedge clk) begin
		pick_t want;
		if (arst_n && done) begin
			if (pending_picks.size() == 0) begin
				report_mismatch("unexpected result, status", status, 0);
			end else begin
				want = pending_picks.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (chosen_backend !== want.backend)
					report_mismatch("chosen_backend", chosen_backend, want.backend);
			end
		end
	end

	// Sender pacing: bursts of random length, gaps of random length
	task automatic pace_sender();
		if (!pacing_on)
			return;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start = 1'b0;
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 40)) @(negedge clk);
			else
				repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(0, 12);
		end
	endtask

	// One request transfer; start stays high when the burst goes on
	task automatic send_item(logic [1:0] op, logic [CIDX_W-1:0] client, logic [BIDX_W-1:0] bidx);
		start       = 1'b1;
		req_op      = op;
		req_client  = client;
		req_backend = bidx;
		do @(posedge clk); while (busy);
		pending_picks = {pending_picks, predict_pick(op, client, bidx)};
		@(negedge clk);
		pace_sender();
	endtask

	task automatic wait_for_results();
		start = 1'b0;
		while (pending_picks.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register writes happen only with the block idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] data);
		wait_for_results();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Out of reset no backend is in use
	task automatic test_reset_state();
		send_item(OP_ROUTE, 4'd0, 2'd0);
		send_item(OP_STICKY, 4'd15, 2'd3);
		send_item(OP_COMPLETE, 4'd0, 2'd0);
		send_item(OP_UNUSED, 4'd15, 2'd3);
	endtask

	// Ticket order with a zero-weight backend and cursor wrap
	task automatic test_weighted_rotation();
		write_reg(REG_BACKENDS, 8'd4);
		write_reg(REG_HEALTH, 8'hff);
		write_reg(REG_WEIGHT0, 8'd1);
		write_reg(REG_WEIGHT1, 8'd2);
		write_reg(REG_WEIGHT2, 8'd0);
		write_reg(REG_WEIGHT3, 8'd3);
		repeat (7) send_item(OP_ROUTE, 4'd0, 2'd0);
		send_item(OP_STICKY, 4'd0, 2'd0);
		send_item(OP_STICKY, 4'd0, 2'd0);
		send_item(OP_STICKY, 4'd15, 2'd1);
	endtask

	// First completion turns on least-in-flight selection
	task automatic test_least_inflight();
		send_item(OP_COMPLETE, 4'd0, 2'd1);
		repeat (3) send_item(OP_ROUTE, 4'd0, 2'd0);
		send_item(OP_COMPLETE, 4'd0, 2'd2);
		send_item(OP_COMPLETE, 4'd0, 2'd3);
		send_item(OP_ROUTE, 4'd0, 2'd0);
	endtask

	// No healthy backend, no tickets, clamped and shrinking backend set
	task automatic test_pool_limits();
		write_reg(REG_HEALTH, 8'd0);
		send_item(OP_ROUTE, 4'd0, 2'd0);
		send_item(OP_STICKY, 4'd0, 2'd0);
		write_reg(REG_HEALTH, 8'b0100);
		send_item(OP_ROUTE, 4'd0, 2'd0);
		write_reg(REG_HEALTH, 8'hff);
		write_reg(REG_WEIGHT2, 8'd255);
		write_reg(REG_BACKENDS, 8'd7);
		send_item(OP_STICKY, 4'd5, 2'd0);
		send_item(OP_ROUTE, 4'd0, 2'd0);
		send_item(OP_STICKY, 4'd15, 2'd0);
		write_reg(REG_BACKENDS, 8'd2);
		send_item(OP_STICKY, 4'd15, 2'd0);
		send_item(OP_COMPLETE, 4'd0, 2'd3);
		write_reg(REG_SPARE_LO, 8'hff);
		write_reg(REG_SPARE_HI, 8'hff);
		send_item(OP_ROUTE, 4'd0, 2'd0);
	endtask

	// Load one count with sticky hits, drain it to zero, then try one completion more
	task automatic test_count_drain();
		pacing_on = 1'b0;
		write_reg(REG_BACKENDS, 8'd1);
		write_reg(REG_HEALTH, 8'd1);
		write_reg(REG_WEIGHT0, 8'd1);
		send_item(OP_STICKY, 4'd3, 2'd0);
		repeat (LOAD_HITS) send_item(OP_STICKY, 4'd3, 2'd0);
		repeat (LOAD_HITS + 1) send_item(OP_COMPLETE, 4'd0, 2'd0);
		send_item(OP_COMPLETE, 4'd0, 2'd0);
		wait_for_results();
		pacing_on = 1'b1;
	endtask

	function automatic logic [WEIGHT_W-1:0] random_weight();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 6)
			return WEIGHT_W'($urandom_range(1, 4));
		else if (roll < 8)
			return WEIGHT_W'($urandom_range(0, 8));
		else if (roll < 9)
			return 8'd255;
		return WEIGHT_W'($urandom_range(0, 255));
	endfunction

	task automatic random_config();
		if ($urandom_range(0, 1))
			write_reg(REG_BACKENDS, ($urandom_range(0, 9) < 7) ? 8'd4 :
				WEIGHT_W'($urandom_range(0, 7)));
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_HEALTH, ($urandom_range(0, 9) < 8) ?
				WEIGHT_W'($urandom_range(1, 15)) : WEIGHT_W'($urandom_range(0, 15)));
		if ($urandom_range(0, 2) == 0) begin
			write_reg(REG_WEIGHT0, random_weight());
			write_reg(REG_WEIGHT1, random_weight());
			write_reg(REG_WEIGHT2, random_weight());
			write_reg(REG_WEIGHT3, random_weight());
		end
		if ($urandom_range(0, 7) == 0)
			write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
				WEIGHT_W'($urandom()));
	endtask

	// Mostly routes, sticky requests and completions of loaded backends
	task automatic random_request();
		int                roll;
		int                loaded [$];
		logic [1:0]        op;
		logic [BIDX_W-1:0] bidx;
		roll = $urandom_range(0, 99);
		op   = (roll < 36) ? OP_ROUTE : (roll < 68) ? OP_STICKY :
			(roll < 95) ? OP_COMPLETE : OP_UNUSED;
		bidx = BIDX_W'($urandom_range(0, NUM_BACKENDS - 1));
		if (op == OP_COMPLETE && $urandom_range(0, 9) < 8) begin
			for (int i = 0; i < live_backends(); i++)
				if (m_inflight[i] != '0)
					loaded = {loaded, i};
			if (loaded.size() != 0)
				bidx = BIDX_W'(loaded[$urandom_range(0, loaded.size() - 1)]);
		end
		send_item(op, CIDX_W'($urandom_range(0, NUM_CLIENTS - 1)), bidx);
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 12; phase++) begin
			random_config();
			pacing_on = ($urandom_range(0, 3) != 0);
			repeat (48) random_request();
		end
		pacing_on = 1'b1;
	endtask

	initial begin
		reset_model();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_state();
		test_weighted_rotation();
		test_least_inflight();
		test_pool_limits();
		test_count_drain();
		test_random_traffic();
		wait_for_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#3000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
hw/rtl/wlib_pkg.sv
hw/rtl/weighted_least_inflight_balancer.sv
tb/tb_top.sv
